// File: hdl/fds_pkg.sv
// shared types, constants and coefficient tables of the finite-difference stencil unit
package fds_pkg;

	// fixed field widths
	localparam int SAMPLE_WIDTH = 32;
	localparam int DERIV_WIDTH  = 48;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_INDEX_W  = 2;
	localparam int TAP_W        = 3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_POINTS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ORDER  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SHIFT  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP   = 2'd3;

	// stencil size codes
	localparam logic [1:0] POINTS_3       = 2'd0;
	localparam logic [1:0] POINTS_INVALID = 2'd3;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] STEP_RESET = 32'd65536;

	// saturation limits of the derivative
	localparam logic [DERIV_WIDTH-1:0] DERIV_MAX = {1'b0, {(DERIV_WIDTH-1){1'b1}}};
	localparam logic [DERIV_WIDTH-1:0] DERIV_MIN = {1'b1, {(DERIV_WIDTH-1){1'b0}}};

	// coefficients scaled by 180: [order][evaluated position][tap]
	localparam int TAB3 [2][3][3] = '{
		'{'{-270, 360, -90}, '{-90, 0, 90}, '{90, -360, 270}},
		'{'{180, -360, 180}, '{180, -360, 180}, '{180, -360, 180}}};

	localparam int TAB5 [2][5][5] = '{
		'{'{-375, 720, -540, 240, -45}, '{-45, -150, 270, -90, 15},
			'{15, -120, 0, 120, -15}, '{-15, 90, -270, 150, 45},
			'{45, -240, 540, -720, 375}},
		'{'{525, -1560, 1710, -840, 165}, '{165, -300, 90, 60, -15},
			'{-15, 240, -450, 240, -15}, '{-15, 60, 90, -300, 165},
			'{165, -840, 1710, -1560, 525}}};

	localparam int TAB7 [2][7][7] = '{
		'{'{-441, 1080, -1350, 1200, -675, 216, -30},
			'{-30, -231, 450, -300, 150, -45, 6},
			'{6, -72, -105, 240, -90, 24, -3},
			'{-3, 27, -135, 0, 135, -27, 3},
			'{3, -24, 90, -240, 105, 72, -6},
			'{-6, 45, -150, 300, -450, 231, 30},
			'{30, -216, 675, -1200, 1350, -1080, 441}},
		'{'{812, -3132, 5265, -5080, 2970, -972, 137},
			'{137, -147, -255, 470, -285, 93, -13},
			'{-13, 228, -420, 200, 15, -12, 2},
			'{2, -27, 270, -490, 270, -27, 2},
			'{2, -12, 15, 200, -420, 228, -13},
			'{-13, 93, -285, 470, -255, -147, 137},
			'{137, -972, 2970, -5080, 5265, -3132, 812}}};

	// item and result payloads
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           line_start;
	} item_t;

	typedef struct packed {
		logic signed [DERIV_WIDTH-1:0] derivative;
		logic                          window_full;
		logic                          config_error;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic shift;
		logic load_row;
		logic mac;
		logic scale;
		logic sum;
		logic load_out;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic             go;
		logic             full;
		logic             err;
		logic [TAP_W-1:0] pts;
	} status_t;

	// scaled coefficient, zero outside the tables
	function automatic int coef180(int code, int ord, int row, int col);
		int v;
		v = 0;
		if (ord >= 0 && ord < 2 && row >= 0 && col >= 0) begin
			if (code == 0 && row < 3 && col < 3)
				v = TAB3[ord][row][col];
			else if (code == 1 && row < 5 && col < 5)
				v = TAB5[ord][row][col];
			else if (code == 2 && row < 7 && col < 7)
				v = TAB7[ord][row][col];
		end
		return v;
	endfunction

	// p/180 in fixed point, rounded half away from zero
	function automatic longint coef_fix(int p, int frac);
		longint m;
		longint q;
		m = (p < 0) ? -longint'(p) : longint'(p);
		q = ((m << frac) + 90) / 180;
		return (p < 0) ? -q : q;
	endfunction

endpackage

// File: hdl/fds_ctrl.sv
// sequencing state machine of the finite-difference stencil unit
module fds_ctrl import fds_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	output logic    result_valid,
	input  logic    result_ready,
	input  status_t sts,
	output cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_MAC   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_SCALE = 3'd4;
	localparam logic [2:0] ST_SUM   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [TAP_W-1:0] tap_q;
	logic             result_valid_q;
	logic             out_free;
	logic             tap_last;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign out_free     = !result_valid_q || result_ready;
	assign tap_last     = (tap_q == sts.pts - TAP_W'(1));

	// commands to the datapath
	always_comb begin
		cmd          = '0;
		cmd.shift    = item_valid && item_ready;
		cmd.load_row = (state_q == ST_EVAL) && sts.go;
		cmd.mac      = (state_q == ST_MAC);
		cmd.scale    = (state_q == ST_SCALE);
		cmd.sum      = (state_q == ST_SUM);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid)
					state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = sts.go ? ST_MAC : ST_DONE;
			end
			ST_MAC: begin
				if (tap_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_SCALE;
			ST_SCALE: state_d = ST_SUM;
			ST_SUM:   state_d = ST_DONE;
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// state, tap counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tap_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EVAL)
				tap_q <= '0;
			else if (state_q == ST_MAC)
				tap_q <= tap_q + TAP_W'(1);
			if (cmd.load_out)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	// an accepted item always goes to evaluation
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q == ST_EVAL))
		else $error("accepted item did not enter evaluation");

	// the tap counter stays inside the stencil
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (tap_q < sts.pts))
		else $error("tap counter beyond stencil size");

	// no accumulation when the window gives no derivative
	a_skip_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && !sts.go) |=> (state_q == ST_DONE))
		else $error("accumulation started without a valid window");

	// a finished item is offered once the output slot is free
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (result_valid && state_q == ST_IDLE))
		else $error("finished item not offered");

endmodule

// File: hdl/fds_datapath.sv
// sample window, coefficient rows, multiply-accumulate and scaling of the stencil unit
module fds_datapath import fds_pkg::*; #(
	parameter int MAX_POINTS     = 7,
	parameter int COEF_FRAC_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  item_t                  item,
	input  cmd_t                   cmd,
	output status_t                sts,
	output result_t                result
);

	localparam int CW  = COEF_FRAC_BITS + 6;
	localparam int AW  = SAMPLE_WIDTH + CW + 3;
	localparam int HW  = AW - 32;
	localparam int PW  = AW + 33;
	localparam int SH  = COEF_FRAC_BITS + 16;
	localparam int SVW = PW - SH;
	localparam int FW  = $clog2(MAX_POINTS + 1);
	localparam logic [PW-1:0] RND = PW'(1) << (SH - 1);

	// configuration registers
	logic [1:0]            points_q;
	logic                  order_q;
	logic [2:0]            shift_q;
	logic [CFG_DATA_W-1:0] step_q;

	logic [FW-1:0]                  fill_q;
	logic signed [SAMPLE_WIDTH-1:0] win_q [MAX_POINTS];
	logic signed [SAMPLE_WIDTH-1:0] op_q  [MAX_POINTS];
	logic signed [CW-1:0]           cq_q  [MAX_POINTS];
	logic signed [CW-1:0]           coef_rom [4][2][8][MAX_POINTS];

	logic signed [SAMPLE_WIDTH+CW-1:0] prod_s1;
	logic                              vld_s1;
	logic signed [AW-1:0]              acc_q;
	logic [63:0]                       pl_s2;
	logic signed [HW+31:0]             ph_s2;
	logic signed [PW-1:0]              sum_q;

	logic [3:0]             pts4;
	logic                   size_ok;
	logic signed [PW-1:0]   shifted;
	logic signed [SVW-1:0]  sv;
	logic                   ovf;
	logic [DERIV_WIDTH-1:0] sat;
	result_t                res_q;

	// coefficient rows, aligned to the newest end of the window
	for (genvar gc = 0; gc < 4; gc++) begin : g_code
		for (genvar go = 0; go < 2; go++) begin : g_ord
			for (genvar gr = 0; gr < 8; gr++) begin : g_row
				for (genvar gk = 0; gk < MAX_POINTS; gk++) begin : g_tap
					localparam int P   = 3 + 2 * gc;
					localparam int COL = gk - (MAX_POINTS - P);
					assign coef_rom[gc][go][gr][gk] =
						(gc < 3 && P <= MAX_POINTS && gr < P && COL >= 0) ?
						CW'(coef_fix(coef180(gc, go, gr, COL), COEF_FRAC_BITS)) : '0;
				end
			end
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= POINTS_3;
			order_q  <= 1'b0;
			shift_q  <= '0;
			step_q   <= STEP_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_POINTS: points_q <= cfg_data[1:0];
				REG_ORDER:  order_q  <= cfg_data[0];
				REG_SHIFT:  shift_q  <= cfg_data[2:0];
				REG_STEP:   step_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	// fill count, restarts on a line start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (cmd.shift) begin
			if (item.line_start)
				fill_q <= FW'(1);
			else if (fill_q != FW'(MAX_POINTS))
				fill_q <= fill_q + FW'(1);
		end
	end

	// delay line, newest sample at the top
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int k = 0; k < MAX_POINTS - 1; k++)
				win_q[k] <= item.line_start ? '0 : win_q[k+1];
			win_q[MAX_POINTS-1] <= item.sample;
		end
	end

	// window state and configuration checks
	always_comb begin
		pts4     = 4'({points_q, 1'b0}) + 4'd3;
		size_ok  = (points_q != POINTS_INVALID) && (pts4 <= 4'(MAX_POINTS));
		sts      = '0;
		sts.err  = !size_ok || ({1'b0, shift_q} >= pts4);
		sts.full = size_ok && (4'(fill_q) >= pts4);
		sts.go   = sts.full && !sts.err;
		sts.pts  = pts4[TAP_W-1:0];
	end

	// operand rows, shifted towards the multiplier one tap a cycle
	always_ff @(posedge clk) begin
		if (cmd.load_row) begin
			for (int k = 0; k < MAX_POINTS; k++) begin
				op_q[k] <= win_q[k];
				cq_q[k] <= coef_rom[points_q][order_q][shift_q][k];
			end
		end else if (cmd.mac) begin
			for (int k = 1; k < MAX_POINTS; k++) begin
				op_q[k] <= op_q[k-1];
				cq_q[k] <= cq_q[k-1];
			end
		end
	end

	// product valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= cmd.mac;
	end

	// shared tap multiplier and accumulator
	always_ff @(posedge clk) begin
		if (cmd.mac)
			prod_s1 <= op_q[MAX_POINTS-1] * cq_q[MAX_POINTS-1];
		if (cmd.load_row)
			acc_q <= '0;
		else if (vld_s1)
			acc_q <= acc_q + AW'(prod_s1);
	end

	// scaling by the reciprocal step in two partial products
	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			pl_s2 <= 64'(acc_q[31:0]) * 64'(step_q);
			ph_s2 <= $signed(acc_q[AW-1:32]) * $signed({1'b0, step_q});
		end
		if (cmd.sum)
			sum_q <= (PW'(ph_s2) << 32) + PW'(pl_s2) + RND;
	end

	// drop fraction bits and saturate
	always_comb begin
		shifted = sum_q >>> SH;
		sv      = shifted[SVW-1:0];
		ovf     = (sv != SVW'($signed(sv[DERIV_WIDTH-1:0])));
		if (ovf)
			sat = sv[SVW-1] ? DERIV_MIN : DERIV_MAX;
		else
			sat = sv[DERIV_WIDTH-1:0];
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.derivative   <= sts.go ? sat : '0;
			res_q.window_full  <= sts.full;
			res_q.config_error <= sts.err;
		end
	end

	assign result = res_q;

endmodule

// File: hdl/finite_difference_stencil_unit.sv
// top level of the finite-difference derivative stencil unit
//
// channel   direction  handshake                    payload
// item      in         item_valid / item_ready      item_t: sample, line_start
// result    out        result_valid / result_ready  result_t: derivative, window_full,
//                                                    config_error
// config    in         cfg_write                    cfg_index, cfg_data
//
// an item giving a derivative passes, between its transfer and the next, through row load, one
// tap a cycle on one shared multiplier, closing accumulate, two steps of scaling and rounding,
// saturation into the output register and a return to idle, where the next item is taken.
// an item without a derivative (window not full or bad configuration) skips to the output.
// reset is asynchronous and needs no clearing pass; it restores the register defaults.
// a result not yet transferred holds the next item in its last state until it leaves.
module finite_difference_stencil_unit import fds_pkg::*; #(
	parameter int MAX_POINTS     = 7,
	parameter int COEF_FRAC_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  item_t                  item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cmd_t    cmd;
	status_t sts;

	// sequencing
	fds_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// window and arithmetic
	fds_datapath #(
		.MAX_POINTS     (MAX_POINTS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

endmodule

// File: dv/tb_top.sv
// self-checking testbench of the finite-difference derivative stencil unit
`timescale 1ns / 100ps

module tb_top;
	import fds_pkg::*;

	// size and order codes not named in the package
	localparam logic [1:0] POINTS_5     = 2'd1;
	localparam logic [1:0] POINTS_7     = 2'd2;
	localparam logic       ORDER_FIRST  = 1'b0;
	localparam logic       ORDER_SECOND = 1'b1;
	localparam int         COEF_FRAC    = 24;
	localparam int         WIN_DEPTH    = 7;
	localparam int         LINE_ITEMS   = 50;

	// 48-bit signed limits held at accumulator width
	localparam logic signed [127:0] ACC_TOP    = (128'sd1 <<< 47) - 128'sd1;
	localparam logic signed [127:0] ACC_BOTTOM = -(128'sd1 <<< 47);

	// stencil weights times 180: [order][evaluated position][tap]
	localparam int DIFF3 [2][3][3] = '{
		'{'{-270, 360, -90}, '{-90, 0, 90}, '{90, -360, 270}},
		'{'{180, -360, 180}, '{180, -360, 180}, '{180, -360, 180}}};

	localparam int DIFF5 [2][5][5] = '{
		'{'{-375, 720, -540, 240, -45}, '{-45, -150, 270, -90, 15},
			'{15, -120, 0, 120, -15}, '{-15, 90, -270, 150, 45},
			'{45, -240, 540, -720, 375}},
		'{'{525, -1560, 1710, -840, 165}, '{165, -300, 90, 60, -15},
			'{-15, 240, -450, 240, -15}, '{-15, 60, 90, -300, 165},
			'{165, -840, 1710, -1560, 525}}};

	localparam int DIFF7 [2][7][7] = '{
		'{'{-441, 1080, -1350, 1200, -675, 216, -30},
			'{-30, -231, 450, -300, 150, -45, 6},
			'{6, -72, -105, 240, -90, 24, -3},
			'{-3, 27, -135, 0, 135, -27, 3},
			'{3, -24, 90, -240, 105, 72, -6},
			'{-6, 45, -150, 300, -450, 231, 30},
			'{30, -216, 675, -1200, 1350, -1080, 441}},
		'{'{812, -3132, 5265, -5080, 2970, -972, 137},
			'{137, -147, -255, 470, -285, 93, -13},
			'{-13, 228, -420, 200, 15, -12, 2},
			'{2, -27, 270, -490, 270, -27, 2},
			'{2, -12, 15, 200, -420, 228, -13},
			'{-13, 93, -285, 470, -255, -147, 137},
			'{137, -972, 2970, -5080, 5265, -3132, 812}}};

	// block ports
	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   item_ready;
	item_t                  item         = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	result_t                result;
	logic                   cfg_write    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	// register copy used for prediction
	logic [1:0]            set_points = POINTS_3;
	logic                  set_order  = ORDER_FIRST;
	logic [2:0]            set_shift  = 3'd0;
	logic [CFG_DATA_W-1:0] set_step   = STEP_RESET;

	// line state of the predictor
	logic signed [SAMPLE_WIDTH-1:0] line_win [WIN_DEPTH];
	int                             line_fill = 0;

	// traffic bookkeeping
	item_t   samples_pending [$];
	result_t derivs_due      [$];
	int      samples_queued  = 0;
	int      samples_taken   = 0;
	int      derivs_seen     = 0;
	int      mismatches      = 0;
	int      n_settings      = 0;
	int      n_lines         = 0;
	int      n_derivs        = 0;
	int      n_clipped       = 0;
	int      n_cfg_errors    = 0;
	bit      item_moved      = 1'b0;
	bit      steady          = 1'b0;

	finite_difference_stencil_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stencil weight p/180 in Q6.24, halves rounded away from zero
	function automatic longint weight_q24(int npts, logic ord, int row, int col);
		int     p;
		longint mag;
		longint q;
		case (npts)
			3:       p = DIFF3[ord][row][col];
			5:       p = DIFF5[ord][row][col];
			default: p = DIFF7[ord][row][col];
		endcase
		mag = (p < 0) ? -p : p;
		q = ((mag << COEF_FRAC) + 90) / 180;
		return (p < 0) ? -q : q;
	endfunction

	// shift one sample into the line and work out the derivative it yields
	function automatic result_t predict_derivative(item_t it);
		logic signed [127:0] acc;
		logic signed [127:0] tap;
		logic signed [127:0] scale;
		int                  npts;
		int                  i;
		bit                  size_ok;
		bit                  bad_cfg;
		bit                  full;
		result_t             r;
		if (it.line_start) begin
			for (i = 0; i < WIN_DEPTH; i++)
				line_win[i] = '0;
			line_fill = 0;
			n_lines++;
		end
		for (i = 0; i < WIN_DEPTH - 1; i++)
			line_win[i] = line_win[i + 1];
		line_win[WIN_DEPTH - 1] = it.sample;
		if (line_fill < WIN_DEPTH)
			line_fill++;

		npts    = 3 + 2 * int'(set_points);
		size_ok = (set_points != POINTS_INVALID);
		bad_cfg = !size_ok || int'(set_shift) >= npts;
		full    = size_ok && line_fill >= npts;

		r              = '0;
		r.window_full  = full;
		r.config_error = bad_cfg;
		if (bad_cfg)
			n_cfg_errors++;
		if (full && !bad_cfg) begin
			// exact dot product, oldest sample on the first tap
			acc = '0;
			for (i = 0; i < npts; i++) begin
				tap = line_win[WIN_DEPTH - npts + i];
				acc = acc + tap * weight_q24(npts, set_order, int'(set_shift), i);
			end
			scale = {96'd0, set_step};
			acc = acc * scale;
			// drop 40 fraction bits, halves toward plus infinity
			acc = (acc + (128'sd1 <<< (COEF_FRAC + 15))) >>> (COEF_FRAC + 16);
			if (acc > ACC_TOP) begin
				r.derivative = DERIV_MAX;
				n_clipped++;
			end else if (acc < ACC_BOTTOM) begin
				r.derivative = DERIV_MIN;
				n_clipped++;
			end else begin
				r.derivative = acc[DERIV_WIDTH-1:0];
			end
			n_derivs++;
		end
		return r;
	endfunction

	// item driver, fed from the pending queue
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_moved) begin
			if (samples_pending.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
				item       <= samples_pending.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls
	always @(negedge clk) begin
		result_ready <= steady || ($urandom_range(99) >= 30);
	end

	// monitor: predict on each item transfer, check each result transfer
	always @(posedge clk) begin
		result_t want;
		item_moved = arst_n && item_valid && item_ready;
		if (item_moved) begin
			derivs_due.push_back(predict_derivative(item));
			samples_taken++;
		end
		if (arst_n && result_valid && result_ready) begin
			derivs_seen++;
			if (derivs_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result, derivative %0d full %0b error %0b",
						$realtime, result.derivative, result.window_full,
						result.config_error);
			end else begin
				want = derivs_due.pop_front();
				if (result.derivative !== want.derivative ||
					result.window_full !== want.window_full ||
					result.config_error !== want.config_error) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result %0d mismatch, expected derivative %0d full %0b error %0b",
							$realtime, derivs_seen, want.derivative, want.window_full,
							want.config_error);
						$display("    got derivative %0d full %0b error %0b",
							result.derivative, result.window_full, result.config_error);
					end
				end
			end
		end
	end

	// single register write, mirrored into the predictor copy
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_POINTS: set_points = data[1:0];
			REG_ORDER:  set_order  = data[0];
			REG_SHIFT:  set_shift  = data[2:0];
			REG_STEP:   set_step   = data;
			default:    ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// full stencil setting, unused upper data bits randomised
	task automatic set_stencil(logic [1:0] points, logic order, logic [2:0] shift,
		logic [CFG_DATA_W-1:0] step);
		write_reg(REG_POINTS, {$urandom} & ~32'h3 | 32'(points));
		write_reg(REG_ORDER, {$urandom} & ~32'h1 | 32'(order));
		write_reg(REG_SHIFT, {$urandom} & ~32'h7 | 32'(shift));
		write_reg(REG_STEP, step);
		n_settings++;
	endtask

	task automatic push_sample(logic start, logic [SAMPLE_WIDTH-1:0] s);
		item_t it;
		it.sample     = s;
		it.line_start = start;
		samples_pending.push_back(it);
		samples_queued++;
	endtask

	// sender holds off until every derivative is back
	task automatic drain();
		while (samples_taken != samples_queued || derivs_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
		logic [SAMPLE_WIDTH-1:0] s;
		case ($urandom_range(9))
			0:       s = 32'h7FFF_FFFF;
			1:       s = 32'h8000_0000;
			2, 3:    s = $urandom_range(32'h3FFFF, 0) - 32'h20000;
			default: s = $urandom;
		endcase
		return s;
	endfunction

	// reset, directed lines, then random settings and lines
	initial begin
		int               ph;
		int               k;
		int               len;
		int               npts;
		int               count;
		logic [1:0]       pts;
		logic [2:0]       shift;
		logic [CFG_DATA_W-1:0] step;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// register defaults: three points, first order, step of one
		push_sample(1'b1, 32'h7FFF_FFFF);
		push_sample(1'b0, 32'h8000_0000);
		push_sample(1'b0, 32'h0001_0000);
		push_sample(1'b0, 32'h7FFF_FFFF);
		push_sample(1'b0, 32'h8000_0000);
		push_sample(1'b0, 32'h0000_0000);
		// a new line empties the window again
		push_sample(1'b1, 32'h1234_5678);
		drain();

		// seven points, second order, last position, largest step: clipping both ways
		set_stencil(POINTS_7, ORDER_SECOND, 3'd6, 32'hFFFF_FFFF);
		push_sample(1'b1, 32'h8000_0000);
		for (k = 0; k < 7; k++)
			push_sample(1'b0, k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
		drain();

		// invalid size code
		set_stencil(POINTS_INVALID, ORDER_FIRST, 3'd0, STEP_RESET);
		push_sample(1'b1, 32'h0003_0000);
		push_sample(1'b0, 32'hFFFD_0000);
		drain();

		// shift not below the size, fill still reported
		set_stencil(POINTS_5, ORDER_FIRST, 3'd5, STEP_RESET);
		for (k = 0; k < 5; k++)
			push_sample(k == 0, pick_sample());
		drain();

		// zero step
		set_stencil(POINTS_3, ORDER_SECOND, 3'd1, 32'd0);
		for (k = 0; k < 3; k++)
			push_sample(k == 0, pick_sample());
		drain();

		// random settings, each with a run of lines of random content
		for (ph = 0; ph < 8; ph++) begin
			drain();
			steady = (ph == 3);
			case ($urandom_range(9))
				0, 1, 2: pts = POINTS_3;
				3, 4, 5: pts = POINTS_5;
				6, 7, 8: pts = POINTS_7;
				default: pts = POINTS_INVALID;
			endcase
			npts = 3 + 2 * int'(pts);
			if (pts != POINTS_INVALID && $urandom_range(99) < 80)
				shift = 3'($urandom_range(npts - 1, 0));
			else
				shift = 3'($urandom_range(7, 0));
			case ($urandom_range(5))
				0:       step = STEP_RESET;
				1:       step = $urandom_range(32'h40000, 1);
				2:       step = $urandom;
				3:       step = 32'hFFFF_FFFF;
				4:       step = 32'd0;
				default: step = $urandom_range(32'hFFFF, 0);
			endcase
			set_stencil(pts, 1'($urandom_range(1)), shift, step);

			// mostly lines at least as long as the stencil, some cut short to one to three samples
			count = 0;
			while (count < LINE_ITEMS) begin
				if ($urandom_range(99) < 85)
					len = $urandom_range(npts + 15, npts);
				else
					len = $urandom_range(3, 1);
				for (k = 0; k < len; k++)
					push_sample(k == 0, pick_sample());
				count += len;
			end
		end

		drain();
		steady = 1'b0;
		repeat (20) @(posedge clk);

		$display("covered %0d samples in %0d lines over %0d stencil settings after reset",
			samples_taken, n_lines, n_settings);
		$display("%0d derivatives computed, %0d clipped, %0d flagged setting errors",
			n_derivs, n_clipped, n_cfg_errors);
		if (mismatches == 0 && derivs_due.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches, derivs_due.size());
			$display("tb_top failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#5000000;
		$display("timeout with %0d results outstanding", derivs_due.size());
		$display("tb_top failed");
		$finish;
	end

endmodule

// File: files.f
hdl/fds_pkg.sv
hdl/fds_ctrl.sv
hdl/fds_datapath.sv
hdl/finite_difference_stencil_unit.sv
dv/tb_top.sv
